@@ design/cl2n_pkg.sv @@
// Package for the column L2 normalizer: widths, the sequencer state type and
// the result type of the shared subtract/compare unit. No dependencies.
package cl2n_pkg;

   localparam int SAMPLE_W   = 16;  // input sample and normalized result
   localparam int ROWS_W     = 7;   // rows_in_use and element count
   localparam int ROW_IDX_W  = 6;   // row index into the column store
   localparam int MAX_ROWS   = 64;
   localparam int SUM_W      = 37;  // sum of squares
   localparam int SQ_W       = 32;  // one square
   localparam int ROOT_REG_W = 39;  // working root register
   localparam int NORM_W     = 19;  // final root, floor(sqrt(2^36)) = 2^18
   localparam int SU_W       = 40;  // shared unit operand width
   localparam int QUO_W      = 17;  // quotient bits, quotient <= 2^15
   localparam int REM_W      = 20;  // partial remainder
   localparam int NUM_W      = 31;  // dividend a*2^15 + norm/2
   localparam int STEP_W     = 5;
   localparam int ROOT_STEPS = 20;  // one step per bit pair, bit = 4^19 .. 4^0

   localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(MAX_ROWS);
   localparam logic [SAMPLE_W-1:0] Q15_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

   typedef enum logic [2:0] {
      ST_LOAD,    // take samples
      ST_ACC,     // fold square into the sum, check end of column
      ST_ROOT,    // integer square root, one bit pair a cycle
      ST_FETCH,   // read one stored element
      ST_PREP,    // set up the divider
      ST_DIVIDE,  // restoring division, one quotient bit a cycle
      ST_WRITE    // hand result to the output register
   } cl2n_state_type;

   typedef struct packed {
      logic [SU_W-1:0] diff;
      logic            ge;
   } cl2n_sub_res_type;

endpackage

@@ design/cl2n_if.sv @@
// Valid/ready channels of the column L2 normalizer: sample input, result
// output and the rows_in_use write port. Depends on cl2n_pkg.
interface cl2n_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [cl2n_pkg::SAMPLE_W-1:0]   sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface cl2n_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [cl2n_pkg::SAMPLE_W-1:0]   normalized;
   logic        [cl2n_pkg::ROW_IDX_W-1:0]  row_index;
   logic                                   last_of_column;
   logic                                   zero_column;

   modport source (output valid, output normalized, output row_index,
                   output last_of_column, output zero_column, input ready);
   modport sink   (input valid, input normalized, input row_index,
                   input last_of_column, input zero_column, output ready);
endinterface

interface cl2n_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic        [cl2n_pkg::ROWS_W-1:0]     data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ design/cl2n_sub_unit.sv @@
// Shared subtract/compare unit used by the square root and the divider.
// Depends on cl2n_pkg.
module cl2n_sub_unit (
   input  logic [cl2n_pkg::SU_W-1:0] minuend,
   input  logic [cl2n_pkg::SU_W-1:0] subtrahend,
   output cl2n_pkg::cl2n_sub_res_type res
);
   import cl2n_pkg::*;

   always_comb begin
      res.diff = minuend - subtrahend;
      res.ge   = (minuend >= subtrahend);
   end

endmodule

@@ design/column_l2_normalizer_unit.sv @@
// Column L2 normalizer top level. Depends on cl2n_pkg, cl2n_if, cl2n_sub_unit.
// Loading: each sample is accepted, then its square is accumulated before the next
// sample is taken. After the last sample of a column the square root runs, then each
// result goes through fetch, setup, 17 divide steps and write; a zero column skips the
// divide steps. Square root and divider share the one subtract/compare unit, and the
// write waits for a free output slot. Sync active-high reset clears the sequencer,
// sum, count and output valid, and sets rows_in_use to 64; store not cleared.
module column_l2_normalizer_unit (
   input  logic        clock,
   input  logic        reset,
   cl2n_req_if.sink    req_bus,
   cl2n_rsp_if.source  rsp_bus,
   cl2n_csr_if.sink    csr_bus
);
   import cl2n_pkg::*;

   // column store, written while loading, read back in row order
   logic [SAMPLE_W-1:0]   store_mem [MAX_ROWS];
   logic [SAMPLE_W-1:0]   rd_ff;

   cl2n_state_type        state_ff, state_in;
   logic [ROWS_W-1:0]     rows_ff;
   logic [ROWS_W-1:0]     count_ff, count_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;     // sum of squares, then sqrt remainder
   logic [SQ_W-1:0]       sq_ff, sq_in;
   logic [ROOT_REG_W-1:0] root_ff, root_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [ROW_IDX_W-1:0]  k_ff, k_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [QUO_W-1:0]      num_ff, num_in;     // low dividend bits still to shift in
   logic [QUO_W-1:0]      quo_ff, quo_in;
   logic                  neg_ff, neg_in;

   // output register
   logic                  out_valid_ff, out_valid_in;
   logic [SAMPLE_W-1:0]   out_norm_ff, out_norm_in;
   logic [ROW_IDX_W-1:0]  out_row_ff, out_row_in;
   logic                  out_last_ff, out_last_in;
   logic                  out_zero_ff, out_zero_in;

   logic                  req_take;
   logic [ROWS_W-1:0]     rows_eff;
   logic [SAMPLE_W-1:0]   sample_mag;
   logic [SAMPLE_W-1:0]   elem_mag;
   logic [NUM_W-1:0]      dividend;
   logic [NORM_W-1:0]     norm;
   logic [SU_W-1:0]       root_bit;
   logic [SU_W-1:0]       su_a, su_b;
   logic [REM_W-1:0]      trial;
   logic                  is_last;
   logic                  out_slot;
   cl2n_sub_res_type      su_res;

   assign req_bus.ready = (state_ff == ST_LOAD);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.normalized     = out_norm_ff;
   assign rsp_bus.row_index      = out_row_ff;
   assign rsp_bus.last_of_column = out_last_ff;
   assign rsp_bus.zero_column    = out_zero_ff;

   // rows_in_use of 0 acts as 1, above the store depth as the depth
   assign rows_eff = (rows_ff == '0) ? ROWS_W'(1) :
                     (rows_ff > ROWS_W'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS) : rows_ff;

   assign sample_mag = req_bus.sample[SAMPLE_W-1] ? SAMPLE_W'(-req_bus.sample)
                                                  : SAMPLE_W'(req_bus.sample);
   assign sq_in      = sample_mag * sample_mag;

   assign norm     = root_ff[NORM_W-1:0];
   // bit = 4^step
   assign root_bit = SU_W'(1) << {step_ff, 1'b0};
   assign trial    = {rem_ff[REM_W-2:0], num_ff[QUO_W-1]};

   // element magnitude and rounded dividend a * 2^15 + norm / 2
   assign elem_mag = rd_ff[SAMPLE_W-1] ? SAMPLE_W'(-rd_ff) : rd_ff;
   assign dividend = {elem_mag, {(SAMPLE_W-1){1'b0}}} + NUM_W'(norm >> 1);

   assign is_last  = ((ROWS_W'(k_ff) + ROWS_W'(1)) == count_ff);
   assign out_slot = !out_valid_ff || rsp_bus.ready;

   // shared unit: sqrt trial subtract or divider trial subtract
   always_comb begin
      if (state_ff == ST_ROOT) begin
         su_a = SU_W'(sum_ff);
         su_b = SU_W'(root_ff) + root_bit;
      end else begin
         su_a = SU_W'(trial);
         su_b = SU_W'(norm);
      end
   end

   cl2n_sub_unit u_sub (
      .minuend    (su_a),
      .subtrahend (su_b),
      .res        (su_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         rows_ff      <= ROWS_RESET;
         count_ff     <= '0;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
         if (csr_bus.valid && csr_bus.ready) begin
            rows_ff <= csr_bus.data;
         end
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      sq_ff       <= sq_in;
      root_ff     <= root_in;
      step_ff     <= step_in;
      k_ff        <= k_in;
      rem_ff      <= rem_in;
      num_ff      <= num_in;
      quo_ff      <= quo_in;
      neg_ff      <= neg_in;
      out_norm_ff <= out_norm_in;
      out_row_ff  <= out_row_in;
      out_last_ff <= out_last_in;
      out_zero_ff <= out_zero_in;
   end

   // column store: write on accept, registered read in fetch
   always_ff @(posedge clock) begin
      if (req_take) begin
         store_mem[count_ff[ROW_IDX_W-1:0]] <= req_bus.sample;
      end
      if (state_ff == ST_FETCH) begin
         rd_ff <= store_mem[k_ff];
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      root_in      = root_ff;
      step_in      = step_ff;
      k_in         = k_ff;
      rem_in       = rem_ff;
      num_in       = num_ff;
      quo_in       = quo_ff;
      neg_in       = neg_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      out_norm_in  = out_norm_ff;
      out_row_in   = out_row_ff;
      out_last_in  = out_last_ff;
      out_zero_in  = out_zero_ff;

      case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               count_in = count_ff + ROWS_W'(1);
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            sum_in = sum_ff + SUM_W'(sq_ff);
            if (count_ff >= rows_eff) begin
               root_in  = '0;
               step_in  = STEP_W'(ROOT_STEPS - 1);
               state_in = ST_ROOT;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_ROOT: begin
            // v >= root + bit: v -= root + bit, root = root/2 + bit
            if (su_res.ge) begin
               sum_in  = su_res.diff[SUM_W-1:0];
               root_in = (root_ff >> 1) + root_bit[ROOT_REG_W-1:0];
            end else begin
               root_in = root_ff >> 1;
            end
            if (step_ff == '0) begin
               k_in     = '0;
               state_in = ST_FETCH;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         ST_FETCH: begin
            state_in = ST_PREP;
         end
         ST_PREP: begin
            neg_in = rd_ff[SAMPLE_W-1];
            if (norm == '0) begin
               quo_in   = '0;
               state_in = ST_WRITE;
            end else begin
               // top dividend bits are below the divisor since |e| <= norm
               rem_in   = REM_W'(dividend[NUM_W-1:QUO_W]);
               num_in   = dividend[QUO_W-1:0];
               quo_in   = '0;
               step_in  = STEP_W'(QUO_W - 1);
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            rem_in = su_res.ge ? su_res.diff[REM_W-1:0] : trial;
            quo_in = {quo_ff[QUO_W-2:0], su_res.ge};
            num_in = num_ff << 1;
            if (step_ff == '0) begin
               state_in = ST_WRITE;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         ST_WRITE: begin
            if (out_slot) begin
               out_valid_in = 1'b1;
               out_row_in   = k_ff;
               out_last_in  = is_last;
               out_zero_in  = (norm == '0);
               if (neg_ff) begin
                  out_norm_in = SAMPLE_W'(-quo_ff);
               end else if (quo_ff[QUO_W-1:SAMPLE_W-1] != '0) begin
                  out_norm_in = Q15_MAX;  // +1.0 saturates
               end else begin
                  out_norm_in = quo_ff[SAMPLE_W-1:0];
               end
               if (is_last) begin
                  sum_in   = '0;
                  count_in = '0;
                  state_in = ST_LOAD;
               end else begin
                  k_in     = k_ff + ROW_IDX_W'(1);
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // a zero column never carries a nonzero result
   a_zero_col_value: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_zero_ff |-> out_norm_ff == '0)
      else $error("zero column with nonzero result");

   // divider partial remainder stays below the divisor
   a_rem_below_norm: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> REM_W'(norm) > rem_ff)
      else $error("divider remainder out of range");

   // column never exceeds the store depth
   a_count_depth: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ROWS_W'(MAX_ROWS))
      else $error("element count beyond store depth");

   // a result is only loaded from the write state
   a_out_load: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff) == ST_WRITE)
      else $error("result loaded outside write state");

   // after the last result of a column the block is loading again
   a_last_returns: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRITE && out_slot && is_last |=> state_ff == ST_LOAD && count_ff == '0)
      else $error("column not closed after last result");

endmodule

@@ test/tb_column_l2_normalizer_unit.sv @@
`timescale 1ns / 100ps
// Testbench for column_l2_normalizer_unit: random and directed columns, a scoreboard
// that predicts every normalized word. Depends on cl2n_pkg, cl2n_if and the unit.

module tb_column_l2_normalizer_unit;
   import cl2n_pkg::*;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0]  normalized;
      logic        [ROW_IDX_W-1:0] row_index;
      logic                        last_of_column;
      logic                        zero_column;
   } norm_word_type;

   typedef enum {FILL_ZERO, FILL_EXTREME, FILL_SMALL, FILL_SPIKE, FILL_RANDOM} fill_kind_type;

   class column_norm_scoreboard;
      logic [SAMPLE_W-1:0] col_store [MAX_ROWS];
      logic [SUM_W-1:0]    sum_sq;
      logic [ROWS_W-1:0]   fill_count;
      logic [ROWS_W-1:0]   rows_reg;
      norm_word_type       expected_words [$];
      int                  errors;

      function new();
         foreach (col_store[i]) col_store[i] = '0;
         sum_sq     = '0;
         fill_count = '0;
         rows_reg   = ROWS_RESET;
         errors     = 0;
      endfunction

      function void set_rows(logic [ROWS_W-1:0] v);
         rows_reg = v;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      // bit-pair integer square root, floor(sqrt(v))
      function longint unsigned int_root(longint unsigned v);
         longint unsigned root, probe;
         root  = 0;
         probe = 64'd1 << 38;
         while (probe > v) probe >>= 2;
         while (probe != 0) begin
            if (v >= root + probe) begin
               v    = v - (root + probe);
               root = (root >> 1) + probe;
            end else begin
               root = root >> 1;
            end
            probe >>= 2;
         end
         return root;
      endfunction

      function void note_sample(logic signed [SAMPLE_W-1:0] s);
         longint unsigned mag, norm, a, u;
         longint          q;
         int              n, eff;
         logic signed [SAMPLE_W-1:0] e;
         norm_word_type   w;
         mag = (s < 0) ? -longint'(s) : longint'(s);
         col_store[fill_count[ROW_IDX_W-1:0]] = s;
         sum_sq     = sum_sq + SUM_W'(mag * mag);
         fill_count = fill_count + 1'b1;
         eff = rows_reg;
         if (eff < 1) eff = 1;
         if (eff > MAX_ROWS) eff = MAX_ROWS;
         if (fill_count < eff) return;
         // column closes: everything stored so far goes out, even past a shrunk length
         n    = (fill_count > MAX_ROWS) ? MAX_ROWS : fill_count;
         norm = int_root(longint'(sum_sq));
         for (int k = 0; k < n; k++) begin
            e = col_store[k];
            q = 0;
            if (norm != 0) begin
               a = (e < 0) ? -longint'(e) : longint'(e);
               u = (a * 32768 + norm / 2) / norm;
               q = (e < 0) ? -longint'(u) : longint'(u);
               if (q > 32767) q = 32767;
               if (q < -32768) q = -32768;
            end
            w.normalized     = SAMPLE_W'(q);
            w.row_index      = ROW_IDX_W'(k);
            w.last_of_column = (k + 1 == n);
            w.zero_column    = (norm == 0);
            expected_words   = {expected_words, w};
         end
         sum_sq     = '0;
         fill_count = '0;
      endfunction

      function void check_word(norm_word_type got);
         norm_word_type want;
         if (expected_words.size() == 0) begin
            errors++;
            $error("unexpected result word: row_index %0d normalized %0d",
                   got.row_index, got.normalized);
            return;
         end
         want = expected_words.pop_front();
         if (got.normalized !== want.normalized) begin
            errors++;
            $error("normalized: expected %0d, actual %0d", want.normalized, got.normalized);
         end
         if (got.row_index !== want.row_index) begin
            errors++;
            $error("row_index: expected %0d, actual %0d", want.row_index, got.row_index);
         end
         if (got.last_of_column !== want.last_of_column) begin
            errors++;
            $error("last_of_column: expected %0d, actual %0d",
                   want.last_of_column, got.last_of_column);
         end
         if (got.zero_column !== want.zero_column) begin
            errors++;
            $error("zero_column: expected %0d, actual %0d", want.zero_column, got.zero_column);
         end
      endfunction
   endclass

   localparam int RANDOM_WORDS = 360;
   localparam int SETTLE_CYCLES = 8;    // covers the accumulate step of a lone sample
   localparam int TAIL_CYCLES   = 120;  // watch for stray words after the last one

   logic clock = 1'b0;
   logic reset = 1'b1;

   cl2n_req_if req_ch ();
   cl2n_rsp_if rsp_ch ();
   cl2n_csr_if csr_ch ();

   column_norm_scoreboard sb;
   bit no_idle;   // when set, neither side inserts gaps or stalls

   column_l2_normalizer_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch),
      .csr_bus (csr_ch)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Drive one sample word. Valid stays high straight into the next word when the
   // drawn gap is zero, so it is never dropped and raised in the same step.
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.sample <= s;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_sample(s);
   endtask

   // Stop sending and hold off until every predicted word has come back.
   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
   endtask

   // Register writes only while the unit is idle. A partial column may leave the
   // unit busy with its last accumulate, hence the extra settle cycles.
   task automatic write_rows(input int v);
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= ROWS_W'(v);
      do @(posedge clock); while (!csr_ch.ready);
      sb.set_rows(ROWS_W'(v));
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample(fill_kind_type kind, int row,
                                                               int hot_row);
      logic signed [SAMPLE_W-1:0] s;
      case (kind)
         FILL_ZERO: s = '0;
         FILL_EXTREME: begin
            case ($urandom_range(0, 3))
               0:       s = 16'sh7FFF;
               1:       s = 16'sh8000;
               2:       s = 16'sh8001;
               default: s = 16'sh7FFE;
            endcase
         end
         FILL_SMALL: s = SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
         FILL_SPIKE: s = (row == hot_row) ? SAMPLE_W'($urandom) : '0;
         default:    s = SAMPLE_W'($urandom);
      endcase
      return s;
   endfunction

   task automatic send_column(input int len, input fill_kind_type kind);
      int hot_row;
      hot_row = $urandom_range(0, len - 1);
      for (int i = 0; i < len; i++) send_sample(pick_sample(kind, i, hot_row));
   endtask

   // Result side: per word a stall of 0..8 cycles with ready low, then ready high
   // until the word is taken. Fields are sampled at the accepting edge.
   initial begin
      int            stall;
      norm_word_type got;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 8);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         got.normalized     = rsp_ch.normalized;
         got.row_index      = rsp_ch.row_index;
         got.last_of_column = rsp_ch.last_of_column;
         got.zero_column    = rsp_ch.zero_column;
         sb.check_word(got);
      end
   end

   // Main sequence: reset, directed columns, then random phases of settings.
   initial begin
      int            random_words, phase, rows, eff, columns, partial, pick;
      fill_kind_type kind;
      sb = new();
      no_idle       = 1'b0;
      req_ch.valid  <= 1'b0;
      req_ch.sample <= '0;
      csr_ch.valid  <= 1'b0;
      csr_ch.data   <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // one-element columns: +1.0 saturates, most negative, zero norm, unit values
      write_rows(1);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh0000);
      send_sample(16'sh0001);
      send_sample(-16'sd1);

      // two rows: large equal pair, all-zero column, 3-4-5 triangle
      write_rows(2);
      send_sample(16'sh8000);
      send_sample(16'sh8000);
      send_sample(16'sh0000);
      send_sample(16'sh0000);
      send_sample(16'sd3);
      send_sample(-16'sd4);

      // zero length behaves as one
      write_rows(0);
      send_sample(16'sd100);

      // length shrunk mid-column: the six stored words all come out
      write_rows(8);
      send_sample(16'sd1000);
      send_sample(-16'sd2000);
      send_sample(16'sd3000);
      send_sample(-16'sd4000);
      send_sample(16'sd5000);
      write_rows(2);
      send_sample(16'sd6000);

      // random phases; the first few pin the extremes of rows_in_use
      random_words = 0;
      phase        = 0;
      while (random_words < RANDOM_WORDS) begin
         case (phase)
            0: rows = 127;
            1: rows = 64;
            2: rows = 1;
            default: begin
               pick = $urandom_range(0, 9);
               if (pick == 0) rows = 0;
               else if (pick == 1) rows = $urandom_range(65, 127);
               else if (pick == 2) rows = $urandom_range(17, 64);
               else rows = $urandom_range(1, 16);
            end
         endcase
         write_rows(rows);
         no_idle = ($urandom_range(0, 3) == 0);
         eff     = (rows < 1) ? 1 : (rows > MAX_ROWS) ? MAX_ROWS : rows;
         columns = (eff > 16) ? 1 : $urandom_range(1, 4);
         for (int c = 0; c < columns; c++) begin
            pick = $urandom_range(0, 7);
            kind = (pick > 4) ? FILL_RANDOM : fill_kind_type'(pick);
            send_column(eff, kind);
            random_words += eff;
            // sender holds off until the unit has drained
            if ($urandom_range(0, 5) == 0) wait_for_results();
         end
         // leave a column half loaded so the next write lands mid-column
         if (eff > 1 && $urandom_range(0, 3) == 0) begin
            partial = $urandom_range(1, eff - 1);
            send_column(partial, FILL_RANDOM);
            random_words += partial;
         end
         phase++;
      end

      // close any open column so its words are predicted and checked
      write_rows(1);
      send_sample(SAMPLE_W'($urandom));
      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #1000000;
      $display("tb: failure");
      $finish;
   end

endmodule
